// ----- rtl/sanf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_pkg: shared types and constants for the next-fit slot allocator
// Slot table depth, field widths, opcode and status codes, sequencer states.
// -----------------------------------------------------------------------------
package sanf_pkg;

  // table geometry
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // request and response field widths
  localparam int OP_W      = 2;
  localparam int SLOT_IN_W = 16;
  localparam int STATUS_W  = 2;
  localparam int GRANT_W   = 6;
  localparam int COUNT_W   = 7;

  // table limits in the widths where they are compared
  localparam logic [SLOT_IN_W-1:0] SLOTS_LIM = SLOT_IN_W'(SLOTS);
  localparam logic [CNT_W-1:0]     SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(SLOTS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [GRANT_W-1:0]   granted_slot;
    logic                 slot_used;
    logic [COUNT_W-1:0]   used_count;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/sanf_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_req_if: request channel
// Valid/ready handshake carrying an opcode and a slot index.
// -----------------------------------------------------------------------------
interface sanf_req_if;
  logic                            valid;
  logic                            ready;
  logic [sanf_pkg::OP_W-1:0]       opcode;
  logic [sanf_pkg::SLOT_IN_W-1:0]  slot_index;

  modport source (output valid, opcode, slot_index, input ready);
  modport sink   (input valid, opcode, slot_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/sanf_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_rsp_if: response channel
// Valid/ready handshake carrying status, granted slot, occupancy and count.
// -----------------------------------------------------------------------------
interface sanf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sanf_pkg::STATUS_W-1:0]  status;
  logic [sanf_pkg::GRANT_W-1:0]   granted_slot;
  logic                           slot_used;
  logic [sanf_pkg::COUNT_W-1:0]   used_count;

  modport source (output valid, status, granted_slot, slot_used, used_count, input ready);
  modport sink   (input valid, status, granted_slot, slot_used, used_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/sanf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module sanf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sanf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_ctrl: allocator sequencer
// Clears the occupancy RAM after reset, executes one request at a time and
// scans the RAM one entry per cycle for the next free slot after an allocate.
// -----------------------------------------------------------------------------
module sanf_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request side
  input  wire logic                            req_valid,
  input  wire logic [sanf_pkg::OP_W-1:0]       req_opcode,
  input  wire logic [sanf_pkg::SLOT_IN_W-1:0]  req_slot_index,
  output logic                                 req_ready,
  // result side
  output logic                                 done_o,
  input  wire logic                            ack_i,
  output sanf_pkg::result_t                    res_o,
  // occupancy RAM
  output logic                                 ram_we,
  output logic [sanf_pkg::IDX_W-1:0]           ram_waddr,
  output logic                                 ram_wdata,
  output logic                                 ram_re,
  output logic [sanf_pkg::IDX_W-1:0]           ram_raddr,
  input  wire logic                            ram_rdata
);

  sanf_pkg::state_t                   state_r, state_nxt;
  sanf_pkg::op_t                      op_r, op_nxt;
  logic [sanf_pkg::SLOT_IN_W-1:0]     idx_r, idx_nxt;
  logic [sanf_pkg::IDX_W-1:0]         hint_r, hint_nxt;
  logic                               hint_vld_r, hint_vld_nxt;
  logic [sanf_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [sanf_pkg::IDX_W-1:0]         scan_addr_r, scan_addr_nxt;
  logic [sanf_pkg::CNT_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                               chk_vld_r, chk_vld_nxt;
  logic [sanf_pkg::IDX_W-1:0]         chk_addr_r, chk_addr_nxt;
  sanf_pkg::status_t                  status_r, status_nxt;
  logic [sanf_pkg::GRANT_W-1:0]       granted_r, granted_nxt;
  logic                               used_r, used_nxt;

  logic                               accept;
  logic                               idx_ok;
  logic                               alloc_fail;
  logic [sanf_pkg::IDX_W-1:0]         scan_start;
  logic                               scan_issue;
  logic                               found;
  logic                               exhausted;

  // status decode
  assign accept     = req_valid && req_ready;
  assign idx_ok     = (idx_r < sanf_pkg::SLOTS_LIM);
  assign alloc_fail = (count_r >= sanf_pkg::SLOTS_CNT) || !hint_vld_r;
  assign scan_start = hint_vld_r ? hint_r : '0;
  assign scan_issue = (state_r == sanf_pkg::S_SCAN) && (scan_cnt_r != sanf_pkg::SLOTS_CNT);
  assign found      = (state_r == sanf_pkg::S_SCAN) && chk_vld_r && !ram_rdata;
  assign exhausted  = (state_r == sanf_pkg::S_SCAN) && chk_vld_r && ram_rdata &&
                      (scan_cnt_r == sanf_pkg::SLOTS_CNT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sanf_pkg::S_CLEAR: begin
        if (scan_addr_r == sanf_pkg::LAST_IDX) state_nxt = sanf_pkg::S_IDLE;
      end
      sanf_pkg::S_IDLE: begin
        if (accept) state_nxt = sanf_pkg::S_OP;
      end
      sanf_pkg::S_OP: begin
        state_nxt = (op_r == sanf_pkg::OP_ALLOC) ? sanf_pkg::S_SCAN : sanf_pkg::S_DONE;
      end
      sanf_pkg::S_SCAN: begin
        if (found || exhausted) state_nxt = sanf_pkg::S_DONE;
      end
      sanf_pkg::S_DONE: begin
        if (ack_i) state_nxt = sanf_pkg::S_IDLE;
      end
      default: state_nxt = sanf_pkg::S_IDLE;
    endcase
  end

  // handshake and RAM port controls
  always_comb begin
    req_ready = (state_r == sanf_pkg::S_IDLE);
    done_o    = (state_r == sanf_pkg::S_DONE);
    ram_we    = 1'b0;
    ram_waddr = scan_addr_r;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = scan_addr_r;
    priority if (state_r == sanf_pkg::S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == sanf_pkg::S_OP && op_r == sanf_pkg::OP_ALLOC) begin
      ram_we    = !alloc_fail;
      ram_waddr = hint_r;
      ram_wdata = 1'b1;
    end else if (state_r == sanf_pkg::S_OP && op_r == sanf_pkg::OP_FREE) begin
      ram_we    = idx_ok && ram_rdata;
      ram_waddr = idx_r[sanf_pkg::IDX_W-1:0];
    end else if (state_r == sanf_pkg::S_IDLE) begin
      ram_re    = accept;
      ram_raddr = req_slot_index[sanf_pkg::IDX_W-1:0];
    end else if (state_r == sanf_pkg::S_SCAN) begin
      ram_re = scan_issue;
    end else begin
      ram_re = 1'b0;
    end
  end

  // datapath next values
  always_comb begin
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    hint_nxt      = hint_r;
    hint_vld_nxt  = hint_vld_r;
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    scan_cnt_nxt  = scan_cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_addr_nxt  = chk_addr_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    used_nxt      = used_r;
    unique case (state_r)
      sanf_pkg::S_CLEAR: begin
        scan_addr_nxt = scan_addr_r + sanf_pkg::IDX_W'(1);
      end
      sanf_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt      = sanf_pkg::op_t'(req_opcode);
          idx_nxt     = req_slot_index;
          status_nxt  = sanf_pkg::ST_OK;
          granted_nxt = '0;
          used_nxt    = 1'b0;
        end
      end
      sanf_pkg::S_OP: begin
        unique case (op_r)
          sanf_pkg::OP_ALLOC: begin
            scan_addr_nxt = scan_start;
            scan_cnt_nxt  = '0;
            chk_vld_nxt   = 1'b0;
            if (alloc_fail) begin
              status_nxt = sanf_pkg::ST_NONE;
            end else begin
              granted_nxt = sanf_pkg::GRANT_W'(hint_r);
              count_nxt   = count_r + sanf_pkg::CNT_W'(1);
            end
          end
          sanf_pkg::OP_FREE: begin
            if (!idx_ok) begin
              status_nxt = sanf_pkg::ST_RANGE;
            end else if (!ram_rdata) begin
              status_nxt = sanf_pkg::ST_UNUSED;
            end else begin
              if (count_r != '0) count_nxt = count_r - sanf_pkg::CNT_W'(1);
              if (!hint_vld_r) begin
                hint_nxt     = idx_r[sanf_pkg::IDX_W-1:0];
                hint_vld_nxt = 1'b1;
              end
            end
          end
          sanf_pkg::OP_QUERY: begin
            if (!idx_ok) status_nxt = sanf_pkg::ST_RANGE;
            else         used_nxt   = ram_rdata;
          end
          sanf_pkg::OP_NOP: begin
            status_nxt = sanf_pkg::ST_OK;
          end
        endcase
      end
      sanf_pkg::S_SCAN: begin
        // read one entry a cycle, wrapping at the top of the table
        chk_vld_nxt  = scan_issue;
        chk_addr_nxt = scan_addr_r;
        if (scan_issue) begin
          scan_cnt_nxt  = scan_cnt_r + sanf_pkg::CNT_W'(1);
          scan_addr_nxt = (scan_addr_r == sanf_pkg::LAST_IDX) ? '0 :
                          scan_addr_r + sanf_pkg::IDX_W'(1);
        end
        // check the entry read last cycle
        if (found) begin
          hint_nxt     = chk_addr_r;
          hint_vld_nxt = 1'b1;
          chk_vld_nxt  = 1'b0;
        end else if (exhausted) begin
          hint_vld_nxt = 1'b0;
          chk_vld_nxt  = 1'b0;
        end
      end
      sanf_pkg::S_DONE: begin
        chk_vld_nxt = 1'b0;
      end
      default: begin
        chk_vld_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sanf_pkg::S_CLEAR;
      hint_r      <= '0;
      hint_vld_r  <= 1'b1;
      count_r     <= '0;
      scan_addr_r <= '0;
      scan_cnt_r  <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      hint_vld_r  <= hint_vld_nxt;
      count_r     <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    chk_addr_r <= chk_addr_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    used_r     <= used_nxt;
  end

  assign res_o = '{status:       status_r,
                   granted_slot: granted_r,
                   slot_used:    used_r,
                   used_count:   sanf_pkg::COUNT_W'(count_r)};

endmodule
`default_nettype wire

// ----- rtl/slot_allocator_next_fit_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Timing: free, query and no-op pass from the request through the S_OP and S_DONE
//   states to the result register; allocate also runs the next-free scan in
//   S_SCAN, which reads the occupancy RAM one entry per cycle.
// Flow: one request at a time; ready returns once the result is loaded.
// Reset: synchronous, active low; a clearing pass zeroes the RAM first.
// -----------------------------------------------------------------------------
// slot_allocator_next_fit_unit: next-fit free slot allocator
// Occupancy table in a RAM, sequencer with a shared scan, result register.
// -----------------------------------------------------------------------------
module slot_allocator_next_fit_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sanf_req_if.sink     in_req,
  sanf_rsp_if.source   out_rsp
);

  logic                          done;
  logic                          load;
  sanf_pkg::result_t             res;
  logic                          ram_we;
  logic [sanf_pkg::IDX_W-1:0]    ram_waddr;
  logic                          ram_wdata;
  logic                          ram_re;
  logic [sanf_pkg::IDX_W-1:0]    ram_raddr;
  logic                          ram_rdata;
  logic                          out_vld_r, out_vld_nxt;
  sanf_pkg::result_t             out_res_r;

  sanf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_req.valid),
    .req_opcode     (in_req.opcode),
    .req_slot_index (in_req.slot_index),
    .req_ready      (in_req.ready),
    .done_o         (done),
    .ack_i          (load),
    .res_o          (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  sanf_ram #(
    .WIDTH (1),
    .DEPTH (sanf_pkg::SLOTS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register loads when empty or being drained
  assign load = done && (!out_vld_r || out_rsp.ready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load)                    out_vld_nxt = 1'b1;
    else if (out_rsp.ready)      out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.status       = out_res_r.status;
  assign out_rsp.granted_slot = out_res_r.granted_slot;
  assign out_rsp.slot_used    = out_res_r.slot_used;
  assign out_rsp.used_count   = out_res_r.used_count;

endmodule
`default_nettype wire

// ----- rtl/sanf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sanf_checker: port-level assertions for the slot allocator
// Watches both channels and checks response consistency over time.
// -----------------------------------------------------------------------------
module sanf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [sanf_pkg::STATUS_W-1:0]  out_status,
  input wire logic [sanf_pkg::GRANT_W-1:0]   out_granted_slot,
  input wire logic                           out_slot_used,
  input wire logic [sanf_pkg::COUNT_W-1:0]   out_used_count
);

  // a stalled response stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  // the count never exceeds the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_count <= sanf_pkg::COUNT_W'(sanf_pkg::SLOTS))
    else $error("used count above table depth");

  // only a successful request can carry a granted slot
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sanf_pkg::ST_OK |-> out_granted_slot == '0)
    else $error("granted slot on failed request");

  // occupancy is only reported for an accepted lookup
  a_used_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot_used |-> out_status == sanf_pkg::ST_OK)
    else $error("slot_used set with error status");

  // one request at a time: ready drops after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind slot_allocator_next_fit_unit sanf_checker u_sanf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_granted_slot (out_rsp.granted_slot),
  .out_slot_used    (out_rsp.slot_used),
  .out_used_count   (out_rsp.used_count)
);
`default_nettype wire

// ----- verif/slot_allocator_next_fit_unit_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slot_allocator_next_fit_unit_tb: self-checking bench for the next-fit allocator
// Drives allocate, free, query and no-op requests through the request channel.
// A local model of the slot table predicts every response, and each response
// is checked field by field in order. Both channels idle in random bursts, except in the back-to-back test.
// -----------------------------------------------------------------------------
module slot_allocator_next_fit_unit_tb;
  import sanf_pkg::*;

  logic clk;
  logic rst_n;

  sanf_req_if in_req();
  sanf_rsp_if out_rsp();

  slot_allocator_next_fit_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // model of the slot table
  bit                 slot_taken [SLOTS] = '{default: 1'b0};
  logic [6:0]         hint_slot   = '0;
  bit                 hint_held   = 1'b1;
  logic [COUNT_W-1:0] taken_count = '0;

  result_t awaited_responses [$];
  int      mismatches  = 0;
  bit      gaps_on     = 1'b1;
  int      stall_left  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // next-free search: from the hint upward, then wrap from slot 0
  function automatic void seek_free_slot();
    int from;
    from = hint_held ? int'(hint_slot) : 0;
    if (from >= SLOTS) from = 0;
    for (int i = from; i < SLOTS; i++) begin
      if (!slot_taken[i]) begin
        hint_slot = 7'(i);
        hint_held = 1'b1;
        return;
      end
    end
    for (int i = 0; i < from; i++) begin
      if (!slot_taken[i]) begin
        hint_slot = 7'(i);
        hint_held = 1'b1;
        return;
      end
    end
    hint_held = 1'b0;
  endfunction

  // apply one request to the table model and return the response it gives
  function automatic result_t next_fit_outcome(op_t op, logic [SLOT_IN_W-1:0] idx);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (taken_count >= SLOTS || !hint_held || hint_slot >= SLOTS) begin
          seek_free_slot();
          r.status = ST_NONE;
        end else begin
          r.granted_slot = GRANT_W'(hint_slot);
          slot_taken[hint_slot[IDX_W-1:0]] = 1'b1;
          taken_count = taken_count + 1'b1;
          seek_free_slot();
        end
      end
      OP_FREE: begin
        if (idx >= SLOTS) begin
          r.status = ST_RANGE;
        end else if (!slot_taken[idx[IDX_W-1:0]]) begin
          r.status = ST_UNUSED;
        end else begin
          slot_taken[idx[IDX_W-1:0]] = 1'b0;
          if (taken_count > 0) taken_count = taken_count - 1'b1;
          // a release with no hint held becomes the new hint
          if (!hint_held) begin
            hint_slot = 7'(idx[IDX_W-1:0]);
            hint_held = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        if (idx >= SLOTS) r.status = ST_RANGE;
        else r.slot_used = slot_taken[idx[IDX_W-1:0]];
      end
      default: ;
    endcase
    r.used_count = taken_count;
    return r;
  endfunction

  // a slot currently allocated, or any in-range slot when the table is empty
  function automatic logic [SLOT_IN_W-1:0] some_taken_slot();
    int k;
    if (taken_count == 0) return SLOT_IN_W'($urandom_range(0, SLOTS - 1));
    k = $urandom_range(0, int'(taken_count) - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_taken[i]) begin
        if (k == 0) return SLOT_IN_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // index mix: mostly live slots, some in range, some far out of range
  function automatic logic [SLOT_IN_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return SLOT_IN_W'($urandom);
      1:       return SLOT_IN_W'($urandom_range(SLOTS, 16'hffff));
      2, 3, 4: return SLOT_IN_W'($urandom_range(0, SLOTS - 1));
      default: return some_taken_slot();
    endcase
  endfunction

  // send one request, predict its response once it is taken
  task automatic send_request(input op_t op, input logic [SLOT_IN_W-1:0] idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.opcode     <= op;
    in_req.slot_index <= idx;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    awaited_responses.push_back(next_fit_outcome(op, idx));
  endtask

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      send_request(OP_ALLOC, SLOT_IN_W'($urandom));
    else if (r < 75) send_request(OP_FREE, pick_index());
    else if (r < 95) send_request(OP_QUERY, pick_index());
    else             send_request(OP_NOP, SLOT_IN_W'($urandom));
  endtask

  // extremes of the index, every opcode, range and unused-slot errors
  task automatic test_directed();
    send_request(OP_QUERY, 16'd0);
    send_request(OP_FREE, 16'd0);          // slot not in use
    send_request(OP_FREE, 16'hffff);       // out of range
    send_request(OP_FREE, 16'(SLOTS));     // first index past the table
    send_request(OP_QUERY, 16'hffff);
    send_request(OP_QUERY, 16'(SLOTS));
    send_request(OP_QUERY, 16'(SLOTS - 1));
    send_request(OP_NOP, 16'hffff);
    send_request(OP_ALLOC, 16'hffff);      // index ignored
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_QUERY, 16'd0);
    send_request(OP_QUERY, 16'd1);
    send_request(OP_FREE, 16'd0);
    send_request(OP_ALLOC, 16'h5555);      // next fit moves on, not back to 0
    send_request(OP_FREE, 16'd1);
    send_request(OP_FREE, 16'd1);          // double release
    send_request(OP_QUERY, 16'd2);
    send_request(OP_NOP, 16'd0);
    send_request(OP_ALLOC, 16'haaaa);
    send_request(OP_FREE, 16'h8000);
    send_request(OP_QUERY, 16'h7fff);
    send_request(OP_FREE, 16'd2);
    send_request(OP_FREE, 16'd3);
  endtask

  // fill the table, allocate while full, release into a hintless table, drain
  task automatic test_fill_and_drain();
    while (taken_count < SLOTS) begin
      if ($urandom_range(0, 7) == 0) send_request(OP_QUERY, pick_index());
      else send_request(OP_ALLOC, SLOT_IN_W'($urandom));
    end
    repeat ($urandom_range(1, 3)) send_request(OP_ALLOC, SLOT_IN_W'($urandom));
    send_request(OP_FREE, some_taken_slot());
    send_request(OP_ALLOC, SLOT_IN_W'($urandom));
    send_request(OP_ALLOC, SLOT_IN_W'($urandom));
    while (taken_count > 0) begin
      case ($urandom_range(0, 9))
        0:       send_request(OP_ALLOC, SLOT_IN_W'($urandom));
        1:       send_request(OP_FREE, pick_index());
        2:       send_request(OP_QUERY, pick_index());
        default: send_request(OP_FREE, some_taken_slot());
      endcase
    end
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_request();
  endtask

  // sender holds off until every response is back, then resumes
  task automatic test_pause_until_drained();
    repeat (20) send_random_request();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (20) send_random_request();
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_random_request();
  endtask

  // response sink: random stalls and in-order checking
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready) begin
      if (awaited_responses.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = awaited_responses.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          mismatches++;
        end
        if (out_rsp.granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, actual %0d",
                 want.granted_slot, out_rsp.granted_slot);
          mismatches++;
        end
        if (out_rsp.slot_used !== want.slot_used) begin
          $error("slot_used: expected %0d, actual %0d", want.slot_used, out_rsp.slot_used);
          mismatches++;
        end
        if (out_rsp.used_count !== want.used_count) begin
          $error("used_count: expected %0d, actual %0d",
                 want.used_count, out_rsp.used_count);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_rsp.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // reset, test sequence, final verdict
  initial begin
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.opcode     <= OP_NOP;
    in_req.slot_index <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random_mix(300);
    test_pause_until_drained();
    test_fill_and_drain();
    test_random_mix(250);
    test_back_to_back(150);

    in_req.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sanf_pkg.sv
rtl/sanf_req_if.sv
rtl/sanf_rsp_if.sv
rtl/sanf_ram.sv
rtl/sanf_ctrl.sv
rtl/slot_allocator_next_fit_unit.sv
rtl/sanf_checker.sv
verif/slot_allocator_next_fit_unit_tb.sv
